// ===== sv/rbbf_pkg.sv =====
package rbbf_pkg;

    // configuration field widths
    localparam int WS_W  = 4;
    localparam int DIM_W = 10;
    localparam int DIV_W = 2 * WS_W;
    localparam int PIX_W = 24;

    // default sizing
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_MAX_WINDOW = 15;

    // register reset values
    localparam logic [WS_W-1:0]  RST_WINDOW = WS_W'(3);
    localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(512);
    localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(512);

    // register map
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // control from the sequencer to the channel lanes
    typedef struct packed {
        logic clear;
        logic add;
        logic start;
    } t_lane_ctl;

endpackage

// ===== sv/rbbf_if.sv =====
interface rbbf_pix_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, command, red_in, green_in, blue_in, input ready);
    modport sink (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

interface rbbf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;

    modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

// ===== sv/rbbf_ram.sv =====
module rbbf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rbbf_lane.sv =====
module rbbf_lane
    import rbbf_pkg::*;
#(
    parameter int SUM_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_lane_ctl        i_ctl,
    input  logic [7:0]       i_data,
    input  logic [DIV_W-1:0] i_divisor,
    output logic [7:0]       o_quot,
    output logic             o_done
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] r_acc;
    logic [SUM_W-1:0] r_num;
    logic [SUM_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W:0]   trial;
    logic             ge;

    // one quotient bit per cycle
    assign trial = {r_rem, r_num[SUM_W-1]};
    assign ge    = (trial >= {1'b0, r_div});

    // window accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.add) begin
            r_acc <= r_acc + SUM_W'(i_data);
        end
    end

    // restoring divider datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_num <= r_acc;
            r_rem <= '0;
            r_quo <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[SUM_W-2:0], 1'b0};
            r_rem <= ge ? DIV_W'(trial - {1'b0, r_div}) : trial[DIV_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], ge};
        end
    end

    // divider control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // saturate at 255
    assign o_quot = (|r_quo[SUM_W-1:8]) ? 8'hFF : r_quo[7:0];
    assign o_done = r_done;

endmodule

// ===== sv/rbbf_merge.sv =====
module rbbf_merge
    import rbbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic       i_last,
    output logic       o_free,
    rbbf_res_if.source o_res
);

    logic       r_valid;
    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;
    logic       r_last;

    assign o_free = !r_valid || o_res.ready;

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_last  <= i_last;
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.red_out   = r_red;
    assign o_res.green_out = r_green;
    assign o_res.blue_out  = r_blue;
    assign o_res.frame_end = r_last;

endmodule

// ===== sv/rgb_box_blur_filter.sv =====
// RGB box blur over a raster pixel stream.
// i_pix carries requests: command pixel with its three 8-bit components, or
// command flush. o_res carries blurred pixels; frame_end marks the last one.
// Results lag the input by radius*width+radius pixels; after the last pixel
// of a frame one flush per pending result drains the rest. Ignored requests
// (extra pixels, early flushes) give nothing.
// Each result walks its clipped window through the single read port of the
// row store, one pixel a cycle, then runs a bit-serial divide in each of the
// three channel lanes. i_pix.ready is high only between requests. The finished
// result sits in an output register, so the next request is taken while it
// waits; a stalled receiver blocks only the next result. The APB port sets
// window size, width and height; any write to these registers restarts the
// frame. Reset restores 3 / 512 / 512 and empties the pipeline; the row store
// needs no clearing since only written entries are ever read.
module rgb_box_blur_filter
    import rbbf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rbbf_pix_if.sink           i_pix,
    rbbf_res_if.source         o_res,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [31:0]        i_pwdata,
    output logic [31:0]        o_prdata,
    output logic               o_pready
);

    localparam int RING   = MAX_WINDOW + 2;
    localparam int DEPTH  = RING * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int RINGW  = $clog2(RING);
    localparam int COLW   = $clog2(MAX_WIDTH);
    localparam int ROWW   = $clog2(MAX_HEIGHT);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int TOTW   = WW + HW;
    localparam int SEFFW  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = $clog2((MAX_WINDOW + 1) * (MAX_WINDOW + 1) * 255 + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_SCAN, S_DRAIN, S_START, S_DIV, S_HOLD
    } t_state;

    t_state             r_state, n_state;
    logic [WS_W-1:0]    r_ws, n_ws;
    logic [DIM_W-1:0]   r_fw, n_fw;
    logic [DIM_W-1:0]   r_fh, n_fh;
    logic [TOTW-1:0]    r_in_cnt, n_in_cnt;
    logic [COLW-1:0]    r_in_col, n_in_col;
    logic [RINGW-1:0]   r_in_ring, n_in_ring;
    logic [TOTW-1:0]    r_out_cnt, n_out_cnt;
    logic [ROWW-1:0]    r_out_row, n_out_row;
    logic [COLW-1:0]    r_out_col, n_out_col;
    logic [RINGW-1:0]   r_out_ring, n_out_ring;
    logic [ROWW-1:0]    r_r1, n_r1;
    logic [COLW-1:0]    r_c0, n_c0;
    logic [COLW-1:0]    r_c1, n_c1;
    logic [ROWW-1:0]    r_x, n_x;
    logic [RINGW-1:0]   r_x_ring, n_x_ring;
    logic [COLW-1:0]    r_y, n_y;
    logic               r_last, n_last;
    logic               r_rd_vld, n_rd_vld;

    logic [SEFFW-1:0]   s_eff;
    logic [WW-1:0]      w_eff;
    logic [HW-1:0]      h_eff;
    logic [SEFFW-1:0]   rad;
    logic [TOTW-1:0]    total;
    logic [TOTW-1:0]    lag;
    logic [DIV_W-1:0]   divisor;
    logic               cfg_wr;
    logic               pix_acc;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [PIX_W-1:0]   ram_rdata;
    t_lane_ctl          lane_ctl;
    logic [7:0]         q_red, q_green, q_blue;
    logic               done_red, done_green, done_blue;
    logic               merge_free;
    logic               merge_load;

    // effective sizes after clamping
    always_comb begin
        if (r_ws == '0) begin
            s_eff = SEFFW'(1);
        end else if (int'(r_ws) > MAX_WINDOW) begin
            s_eff = SEFFW'(MAX_WINDOW);
        end else begin
            s_eff = SEFFW'(r_ws);
        end
        if (r_fw == '0) begin
            w_eff = WW'(1);
        end else if (int'(r_fw) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_fw);
        end
        if (r_fh == '0) begin
            h_eff = HW'(1);
        end else if (int'(r_fh) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_fh);
        end
    end

    assign rad     = s_eff >> 1;
    assign total   = TOTW'(w_eff) * TOTW'(h_eff);
    assign lag     = TOTW'(TOTW'(rad) * TOTW'(w_eff)) + TOTW'(rad);
    assign divisor = DIV_W'(s_eff) * DIV_W'(s_eff);

    // apb access
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_comb begin
        unique case (i_paddr[3:2])
            REG_WINDOW: o_prdata = 32'(r_ws);
            REG_WIDTH:  o_prdata = 32'(r_fw);
            REG_HEIGHT: o_prdata = 32'(r_fh);
            default:    o_prdata = '0;
        endcase
    end

    // input handshake
    assign i_pix.ready = (r_state == S_IDLE);
    assign pix_acc     = i_pix.valid && (r_state == S_IDLE);

    // row store ports
    assign ram_we    = pix_acc && (i_pix.command == CMD_PIXEL) && (r_in_cnt < total);
    assign ram_waddr = AW'(int'(r_in_ring) * MAX_WIDTH + int'(r_in_col));
    assign ram_raddr = AW'(int'(r_x_ring) * MAX_WIDTH + int'(r_y));

    rbbf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_pix.red_in, i_pix.green_in, i_pix.blue_in}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // lane control
    assign lane_ctl.clear = (r_state == S_SETUP);
    assign lane_ctl.add   = r_rd_vld;
    assign lane_ctl.start = (r_state == S_START);

    rbbf_lane #(.SUM_W(SUM_W)) u_lane_red (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (lane_ctl),
        .i_data (ram_rdata[23:16]), .i_divisor (divisor),
        .o_quot (q_red), .o_done (done_red)
    );

    rbbf_lane #(.SUM_W(SUM_W)) u_lane_green (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (lane_ctl),
        .i_data (ram_rdata[15:8]), .i_divisor (divisor),
        .o_quot (q_green), .o_done (done_green)
    );

    rbbf_lane #(.SUM_W(SUM_W)) u_lane_blue (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (lane_ctl),
        .i_data (ram_rdata[7:0]), .i_divisor (divisor),
        .o_quot (q_blue), .o_done (done_blue)
    );

    assign merge_load = (r_state == S_HOLD) && merge_free;

    rbbf_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (merge_load),
        .i_red   (q_red),
        .i_green (q_green),
        .i_blue  (q_blue),
        .i_last  (r_last),
        .o_free  (merge_free),
        .o_res   (o_res)
    );

    // sequencer next state
    always_comb begin
        int oi, oj, r0, r1, c0, c1, rr, hl, wl, d;
        oi = int'(r_out_row);
        oj = int'(r_out_col);
        rr = int'(rad);
        hl = int'(h_eff) - 1;
        wl = int'(w_eff) - 1;
        r0 = (oi >= rr) ? oi - rr : 0;
        r1 = (oi + rr < hl) ? oi + rr : hl;
        c0 = (oj >= rr) ? oj - rr : 0;
        c1 = (oj + rr < wl) ? oj + rr : wl;
        d  = oi - r0;

        n_state    = r_state;
        n_ws       = r_ws;
        n_fw       = r_fw;
        n_fh       = r_fh;
        n_in_cnt   = r_in_cnt;
        n_in_col   = r_in_col;
        n_in_ring  = r_in_ring;
        n_out_cnt  = r_out_cnt;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_out_ring = r_out_ring;
        n_r1       = r_r1;
        n_c0       = r_c0;
        n_c1       = r_c1;
        n_x        = r_x;
        n_x_ring   = r_x_ring;
        n_y        = r_y;
        n_last     = r_last;
        n_rd_vld   = (r_state == S_SCAN);

        unique case (r_state)
            S_IDLE: begin
                if (pix_acc) begin
                    if (i_pix.command == CMD_PIXEL) begin
                        if (r_in_cnt < total) begin
                            n_in_cnt = r_in_cnt + 1'b1;
                            if (int'(r_in_col) == wl) begin
                                n_in_col  = '0;
                                n_in_ring = (int'(r_in_ring) == RING - 1) ?
                                            '0 : r_in_ring + 1'b1;
                            end else begin
                                n_in_col = r_in_col + 1'b1;
                            end
                            if (r_in_cnt >= lag) begin
                                n_state = S_SETUP;
                            end
                        end
                    end else if (r_in_cnt >= total && r_out_cnt < total) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                n_r1     = ROWW'(r1);
                n_c0     = COLW'(c0);
                n_c1     = COLW'(c1);
                n_x      = ROWW'(r0);
                n_y      = COLW'(c0);
                n_x_ring = (int'(r_out_ring) >= d) ? RINGW'(int'(r_out_ring) - d) :
                           RINGW'(int'(r_out_ring) + RING - d);
                n_last   = (r_out_cnt + 1'b1 >= total);
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                if (r_y == r_c1) begin
                    n_y = r_c0;
                    if (r_x == r_r1) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_x      = r_x + 1'b1;
                        n_x_ring = (int'(r_x_ring) == RING - 1) ? '0 : r_x_ring + 1'b1;
                    end
                end else begin
                    n_y = r_y + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_START;
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (done_red && done_green && done_blue) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (merge_free) begin
                    n_state = S_IDLE;
                    if (r_last) begin
                        n_in_cnt   = '0;
                        n_in_col   = '0;
                        n_in_ring  = '0;
                        n_out_cnt  = '0;
                        n_out_row  = '0;
                        n_out_col  = '0;
                        n_out_ring = '0;
                    end else begin
                        n_out_cnt = r_out_cnt + 1'b1;
                        if (int'(r_out_col) == wl) begin
                            n_out_col  = '0;
                            n_out_row  = r_out_row + 1'b1;
                            n_out_ring = (int'(r_out_ring) == RING - 1) ?
                                         '0 : r_out_ring + 1'b1;
                        end else begin
                            n_out_col = r_out_col + 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // a write to window, width or height restarts the frame
        if (cfg_wr) begin
            unique case (i_paddr[3:2])
                REG_WINDOW: n_ws = i_pwdata[WS_W-1:0];
                REG_WIDTH:  n_fw = i_pwdata[DIM_W-1:0];
                REG_HEIGHT: n_fh = i_pwdata[DIM_W-1:0];
                default: ;
            endcase
            if (i_paddr[3:2] inside {REG_WINDOW, REG_WIDTH, REG_HEIGHT}) begin
                n_in_cnt   = '0;
                n_in_col   = '0;
                n_in_ring  = '0;
                n_out_cnt  = '0;
                n_out_row  = '0;
                n_out_col  = '0;
                n_out_ring = '0;
            end
        end
    end

    // state and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ws       <= RST_WINDOW;
            r_fw       <= RST_WIDTH;
            r_fh       <= RST_HEIGHT;
            r_in_cnt   <= '0;
            r_in_col   <= '0;
            r_in_ring  <= '0;
            r_out_cnt  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_ring <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ws       <= n_ws;
            r_fw       <= n_fw;
            r_fh       <= n_fh;
            r_in_cnt   <= n_in_cnt;
            r_in_col   <= n_in_col;
            r_in_ring  <= n_in_ring;
            r_out_cnt  <= n_out_cnt;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
            r_out_ring <= n_out_ring;
            r_rd_vld   <= n_rd_vld;
        end
        r_r1     <= n_r1;
        r_c0     <= n_c0;
        r_c1     <= n_c1;
        r_x      <= n_x;
        r_x_ring <= n_x_ring;
        r_y      <= n_y;
        r_last   <= n_last;
    end

endmodule
